/* design/rlban_pkg.sv */
package rlban_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int TBL_AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int TBL_CW = $clog2(TABLE_ENTRIES + 1);

  localparam int ADDR_W  = 32;
  localparam int TIME_W  = 64;
  localparam int CNT_W   = 32;
  localparam int SEC_W   = 17;
  localparam int MAXR_W  = 16;
  localparam int NS_W    = 47;
  localparam int IN_W    = ADDR_W + TIME_W;
  localparam int OUT_W   = 184;
  localparam int CFGI_W  = 2;

  localparam logic [29:0]       NS_PER_SEC   = 30'd1000000000;
  // 2^17 seconds in ns: from here on the countdown saturates
  localparam logic [NS_W-1:0]   UNBAN_SAT_NS = 47'd131072000000000;
  localparam logic [SEC_W-1:0]  UNBAN_MAX    = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX      = '1;

  // 1e9 = 2^9 * 1953125: the countdown divides (diff >> 9) by the odd factor
  localparam int NS_POW2 = 9;
  localparam int DVD_W   = NS_W - NS_POW2;
  // top 26 bits of the dividend feed the reciprocal multiply
  localparam int RCP_LO  = DVD_W - 26;
  localparam logic [20:0] NS_ODD   = 21'd1953125;
  // floor(2^44 / 1953125); ((dvd >> 12) * NS_RECIP) >> 32 is low by at most one
  localparam logic [23:0] NS_RECIP = 24'd9007199;

  localparam logic [MAXR_W-1:0] MAX_REQ_RST  = 16'd10;
  localparam logic [SEC_W-1:0]  WIN_SEC_RST  = 17'd300;
  localparam logic [SEC_W-1:0]  BAN_SEC_RST  = 17'd120;

  localparam logic [CFGI_W-1:0] CFG_MAX_REQ  = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_WIN_SEC  = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_BAN_SEC  = 2'd2;

  typedef struct packed {
    logic [MAXR_W-1:0] max_req;
    logic [NS_W-1:0]   win_ns;   // (window_seconds + 1) * 1e9
    logic [NS_W-1:0]   ban_ns;   // ban_seconds * 1e9
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  bc;
    logic [CNT_W-1:0]  rc;
    logic [TIME_W-1:0] be;
    logic [TIME_W-1:0] ws;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* design/rlban_ram.sv */
module rlban_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/rlban_cfg.sv */
module rlban_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rlban_pkg::CFGI_W-1:0] cfg_index,
  input  logic [rlban_pkg::SEC_W-1:0]  cfg_data,
  output rlban_pkg::cfg_t            cfg
);
  import rlban_pkg::*;

  logic [MAXR_W-1:0] max_req_r;
  logic [SEC_W-1:0]  win_sec_r;
  logic [SEC_W-1:0]  ban_sec_r;
  logic [NS_W-1:0]   win_ns_r;
  logic [NS_W-1:0]   ban_ns_r;
  logic [SEC_W:0]    win_p1;
  logic [47:0]       win_prod;
  logic [47:0]       ban_prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_req_r <= MAX_REQ_RST;
      win_sec_r <= WIN_SEC_RST;
      ban_sec_r <= BAN_SEC_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_REQ: max_req_r <= cfg_data[MAXR_W-1:0];
        CFG_WIN_SEC: win_sec_r <= cfg_data;
        CFG_BAN_SEC: ban_sec_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // floor(d / 1e9) > W  <=>  d >= (W + 1) * 1e9
  assign win_p1   = {1'b0, win_sec_r} + (SEC_W + 1)'(1);
  assign win_prod = 48'(win_p1) * 48'(NS_PER_SEC);
  assign ban_prod = 48'(ban_sec_r) * 48'(NS_PER_SEC);

  always_ff @(posedge clk) begin
    win_ns_r <= win_prod[NS_W-1:0];
    ban_ns_r <= ban_prod[NS_W-1:0];
  end

  assign cfg.max_req = max_req_r;
  assign cfg.win_ns  = win_ns_r;
  assign cfg.ban_ns  = ban_ns_r;

endmodule

/* design/rlban_div.sv */
module rlban_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rlban_pkg::DVD_W-1:0] dividend,
  output logic                        done,
  output logic [rlban_pkg::SEC_W-1:0] quotient
);
  import rlban_pkg::*;

  logic             s1_r, s2_r, s3_r, done_r;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [48:0]      prod;
  logic [SEC_W-1:0] q0_r, q0_nxt;
  logic [DVD_W-1:0] qc_r, qc_nxt;
  logic [SEC_W-1:0] quo_r, quo_nxt;
  logic [DVD_W-1:0] rem;

  // estimate by reciprocal multiply, then one compare-and-correct step
  assign dvd_nxt = start ? dividend : dvd_r;
  assign prod    = 49'(dvd_r[DVD_W-1:RCP_LO]) * 49'(NS_RECIP);
  assign q0_nxt  = prod[48:32];
  assign qc_nxt  = DVD_W'(q0_r) * DVD_W'(NS_ODD);
  assign rem     = dvd_r - qc_r;
  assign quo_nxt = q0_r + SEC_W'(rem >= DVD_W'(NS_ODD));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      s3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= start;
      s2_r   <= s1_r;
      s3_r   <= s2_r;
      done_r <= s3_r;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    q0_r  <= q0_nxt;
    qc_r  <= qc_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* design/per_address_rate_limiter_with_ban.sv */
// Per-address rate limiter with ban. Each input word is one connection attempt
// (address, ns timestamp); a nonzero address yields one result word with the
// entry's updated counts, the blocked flag and the whole seconds left in any ban.
// Entries live in two single-port-read RAMs (keys, and window/ban/count data)
// filled in arrival order and never evicted, so no clearing pass is needed
// after reset. An attempt is scanned one key per cycle: an address held in
// slot j is found once slots 0 to j are read, a new address once every slot
// in use is read. The entry then passes the evaluate, update and prepare
// states; a reciprocal-multiply divider runs before the response when the
// result carries a ban countdown below 2^17 s. A zero address is not scanned.
// A finished result sits in the output register while the next word is taken.
module per_address_rate_limiter_with_ban (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [31:0] dst_address, [95:32] now_ns
  input  logic [rlban_pkg::IN_W-1:0]     in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] address_out, [32] blocked, [64:33] request_total,
  // [96:65] blocked_total, [160:97] time_out, [177:161] unban_seconds,
  // [178] not_stored, [183:179] zero
  output logic [rlban_pkg::OUT_W-1:0]    out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rlban_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [rlban_pkg::SEC_W-1:0]    cfg_data
);
  import rlban_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_EVAL   = 7'b0000100,
    ST_UPDATE = 7'b0001000,
    ST_PREP   = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_t;

  localparam logic [TBL_CW-1:0] FULL_CNT = TBL_CW'(TABLE_ENTRIES);

  cfg_t cfg;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [TBL_CW-1:0] count_r, count_nxt;
  logic [TBL_CW-1:0] scan_r, scan_nxt;
  logic              chk_r, chk_nxt;
  logic [TBL_AW-1:0] chk_idx_r, chk_idx_nxt;
  logic [TBL_AW-1:0] slot_r, slot_nxt;
  logic              hit_r, hit_nxt;
  entry_t            ent_r, ent_nxt;
  logic              ban_on_r, ban_on_nxt;
  logic              restart_r, restart_nxt;
  logic              limit_r, limit_nxt;
  logic [TIME_W-1:0] newbe_r, newbe_nxt;
  logic              blk_r, blk_nxt;
  logic              nstored_r, nstored_nxt;
  logic [SEC_W-1:0]  unban_r, unban_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  logic [ADDR_W-1:0] key_rd;
  logic [ENTRY_W-1:0] data_rd;
  entry_t            ent_rd;
  logic              rd_en;
  logic              key_we, data_we;
  entry_t            ent_wr;
  logic              hit_now;
  logic [TIME_W:0]   be_sum;
  logic [TIME_W-1:0] diff;
  logic              div_start, div_done;
  logic [SEC_W-1:0]  div_q;

  rlban_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rlban_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (slot_r),
    .wdata (addr_r),
    .re    (rd_en),
    .raddr (scan_r[TBL_AW-1:0]),
    .rdata (key_rd)
  );

  rlban_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (slot_r),
    .wdata (ent_wr),
    .re    (rd_en),
    .raddr (scan_r[TBL_AW-1:0]),
    .rdata (data_rd)
  );

  rlban_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff[NS_W-1:NS_POW2]),
    .done     (div_done),
    .quotient (div_q)
  );

  assign ent_rd    = entry_t'(data_rd);
  assign in_tready = (state_r == ST_IDLE);
  assign hit_now   = chk_r && (key_rd == addr_r);
  assign be_sum    = {1'b0, now_r} + (TIME_W + 1)'(cfg.ban_ns);
  assign diff      = ent_r.be - now_r;

  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    now_nxt     = now_r;
    count_nxt   = count_r;
    scan_nxt    = scan_r;
    chk_nxt     = 1'b0;
    chk_idx_nxt = chk_idx_r;
    slot_nxt    = slot_r;
    hit_nxt     = hit_r;
    ent_nxt     = ent_r;
    ban_on_nxt  = ban_on_r;
    restart_nxt = restart_r;
    limit_nxt   = limit_r;
    newbe_nxt   = newbe_r;
    blk_nxt     = blk_r;
    nstored_nxt = nstored_r;
    unban_nxt   = unban_r;
    rd_en       = 1'b0;
    key_we      = 1'b0;
    data_we     = 1'b0;
    ent_wr      = ent_r;
    div_start   = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          addr_nxt = in_tdata[ADDR_W-1:0];
          now_nxt  = in_tdata[IN_W-1:ADDR_W];
          scan_nxt = '0;
          if (in_tdata[ADDR_W-1:0] != '0) begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // key read issued one word ahead of the compare
        if (hit_now) begin
          hit_nxt   = 1'b1;
          slot_nxt  = chk_idx_r;
          ent_nxt   = ent_rd;
          state_nxt = ST_EVAL;
        end else if (!chk_r && scan_r == count_r) begin
          hit_nxt   = 1'b0;
          slot_nxt  = count_r[TBL_AW-1:0];
          ent_nxt   = '{bc: '0, rc: '0, be: '0, ws: now_r};
          state_nxt = ST_EVAL;
        end else if (scan_r < count_r) begin
          rd_en       = 1'b1;
          chk_nxt     = 1'b1;
          chk_idx_nxt = scan_r[TBL_AW-1:0];
          scan_nxt    = scan_r + TBL_CW'(1);
        end
      end

      ST_EVAL: begin
        ban_on_nxt  = ent_r.be > now_r;
        restart_nxt = (now_r - ent_r.ws) >= TIME_W'(cfg.win_ns);
        limit_nxt   = ent_r.rc >= CNT_W'(cfg.max_req);
        newbe_nxt   = be_sum[TIME_W] ? '1 : be_sum[TIME_W-1:0];
        state_nxt   = ST_UPDATE;
      end

      ST_UPDATE: begin
        ent_wr  = ent_r;
        blk_nxt = 1'b0;
        if (hit_r) begin
          if (ban_on_r) begin
            blk_nxt = 1'b1;
          end else if (restart_r) begin
            ent_wr = '{bc: '0, rc: '0, be: '0, ws: now_r};
          end else if (limit_r) begin
            ent_wr.be = newbe_r;
            blk_nxt   = 1'b1;
          end
        end
        if (ent_wr.rc != CNT_MAX) begin
          ent_wr.rc = ent_wr.rc + CNT_W'(1);
        end
        if (blk_nxt && ent_wr.bc != CNT_MAX) begin
          ent_wr.bc = ent_wr.bc + CNT_W'(1);
        end
        nstored_nxt = !hit_r && (count_r == FULL_CNT);
        data_we     = hit_r || (count_r != FULL_CNT);
        key_we      = !hit_r && (count_r != FULL_CNT);
        if (key_we) begin
          count_nxt = count_r + TBL_CW'(1);
        end
        ent_nxt   = ent_wr;
        state_nxt = ST_PREP;
      end

      ST_PREP: begin
        if (ent_r.be <= now_r) begin
          unban_nxt = '0;
          state_nxt = ST_RESP;
        end else if (diff >= TIME_W'(UNBAN_SAT_NS)) begin
          unban_nxt = UNBAN_MAX;
          state_nxt = ST_RESP;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          unban_nxt = div_q;
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, nstored_r, unban_r, now_r, ent_r.bc, ent_r.rc,
                           blk_r, addr_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    now_r      <= now_nxt;
    scan_r     <= scan_nxt;
    chk_idx_r  <= chk_idx_nxt;
    slot_r     <= slot_nxt;
    hit_r      <= hit_nxt;
    ent_r      <= ent_nxt;
    ban_on_r   <= ban_on_nxt;
    restart_r  <= restart_nxt;
    limit_r    <= limit_nxt;
    newbe_r    <= newbe_nxt;
    blk_r      <= blk_nxt;
    nstored_r  <= nstored_nxt;
    unban_r    <= unban_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
